// File: hw/rtl/pds_pkg.sv
// Types and constants for the periodic dispatch scheduler.
// Depends on nothing; used by the core and the testbench.
package pds_pkg;

   localparam int TimeBits = 40;
   localparam int IdBits = 16;
   localparam int PeriodBits = 16;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_CLEAR_B  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_REGISTERED = 3'd0,
      ST_DISPATCHED = 3'd1,
      ST_FULL       = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_CLEARED    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_WRITE
   } fsm_type;

   typedef struct packed {
      op_type                  operation;
      logic [IdBits-1:0]       source_id;
      logic [PeriodBits-1:0]   period;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [IdBits-1:0]       dispatched_id;
      logic [TimeBits-1:0]     dispatch_time;
   } rsp_type;

   typedef struct packed {
      logic [TimeBits-1:0]     due;
      logic [IdBits-1:0]       id;
      logic [PeriodBits-1:0]   period;
   } entry_type;

endpackage

// File: hw/rtl/pds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pds_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/periodic_dispatch_scheduler_core.sv
// Periodic dispatch scheduler core: source table in one RAM, linear dispatch scan.
// Depends on pds_pkg and pds_ram.
//
// Register and clear items complete at the accepting edge; busy stays low and the
// next item can be taken in the following cycle. A dispatch reads the table through
// the RAM read port one entry per cycle and holds busy through the write-back (the
// read of slot zero is issued at the accepting edge, then one read per valid
// entry, then the write-back). Each item gives exactly one result, shown for one
// cycle on rsp with rsp_valid in the cycle after the item completes; the receiver
// cannot stall it. Earliest due time wins, then lower id, then lower slot.
module periodic_dispatch_scheduler_core
   import pds_pkg::*;
#(
   parameter int MAX_SOURCES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CW = $clog2(MAX_SOURCES + 1);
   localparam int EW = $bits(entry_type);

   fsm_type          state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   entry_type        best_ff, best_in;
   logic             first_ff, first_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   entry_type        wr_data, rd_entry;
   logic [EW-1:0]    rd_raw;
   logic             accept, earlier, last;
   logic [TimeBits:0] sum;

   pds_ram #(.WIDTH(EW), .DEPTH(MAX_SOURCES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);
   assign accept = start && (state_ff == FSM_IDLE);
   assign busy = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
   assign earlier = (rd_entry.due < best_ff.due) ||
                    ((rd_entry.due == best_ff.due) && (rd_entry.id < best_ff.id));
   assign last = ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);
   assign sum = {1'b0, best_ff.due} + (TimeBits+1)'(best_ff.period);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      first_ff    <= first_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: ST_CLEARED, dispatched_id: '0, dispatch_time: '0};
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{due: TimeBits'(req_item.period), id: req_item.source_id,
                       period: req_item.period};
      rd_addr      = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_item.operation)
                  OP_REGISTER: begin
                     if (count_ff >= CW'(MAX_SOURCES)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                        rsp_in.status = ST_REGISTERED;
                     end
                  end
                  OP_DISPATCH: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        cmp_idx_in = '0;
                        first_in = 1'b1;
                        state_in = FSM_SCAN;
                     end
                  end
                  default: begin
                     count_in = '0;
                     rsp_in.status = ST_CLEARED;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            rd_addr = cmp_idx_ff + AW'(1);
            first_in = 1'b0;
            if (first_ff || earlier) begin
               best_in = rd_entry;
               best_idx_in = cmp_idx_ff;
            end
            if (last) begin
               state_in = FSM_WRITE;
            end else begin
               cmp_idx_in = cmp_idx_ff + AW'(1);
            end
         end
         FSM_WRITE: begin
            wr_en = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = best_ff;
            wr_data.due = sum[TimeBits] ? '1 : sum[TimeBits-1:0];
            rsp_valid_in = 1'b1;
            rsp_in = '{status: ST_DISPATCHED, dispatched_id: best_ff.id,
                       dispatch_time: best_ff.due};
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SOURCES))
      else $error("entry count beyond table size");

   a_write_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_WRITE) |=> (rsp_valid_ff && rsp_ff.status == ST_DISPATCHED
                                   && state_ff == FSM_IDLE))
      else $error("dispatch write-back without result");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |=> !rsp_valid_ff)
      else $error("result during scan");
endmodule

// File: test/periodic_dispatch_scheduler_core_tb.sv
// Testbench for periodic_dispatch_scheduler_core: directed and random register,
// dispatch and clear items checked against an in-bench scan of the source table.
// Depends on pds_pkg and the core RTL.
module periodic_dispatch_scheduler_core_tb;
   import pds_pkg::*;

   localparam int Slots = 64;
   localparam int IdleLimit = 4000;
   localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   req_type pending_items[$];
   rsp_type expected_rsps[$];

   logic [TimeBits-1:0]   due_tbl[Slots];
   logic [IdBits-1:0]     id_tbl[Slots];
   logic [PeriodBits-1:0] period_tbl[Slots];
   int                    source_count = 0;

   int mismatches = 0;
   int gap_cycles;
   int idle_cycles;

   periodic_dispatch_scheduler_core #(.MAX_SOURCES(Slots)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type schedule_step(req_type r);
      rsp_type res;
      int best;
      res = '0;
      case (r.operation)
         OP_REGISTER: begin
            if (source_count >= Slots) begin
               res.status = ST_FULL;
            end else begin
               id_tbl[source_count] = r.source_id;
               period_tbl[source_count] = r.period;
               due_tbl[source_count] = TimeBits'(r.period);
               source_count++;
               res.status = ST_REGISTERED;
            end
         end
         OP_DISPATCH: begin
            if (source_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < source_count; i++)
                  if (due_tbl[i] < due_tbl[best] ||
                      (due_tbl[i] == due_tbl[best] && id_tbl[i] < id_tbl[best]))
                     best = i;
               res.status = ST_DISPATCHED;
               res.dispatched_id = id_tbl[best];
               res.dispatch_time = due_tbl[best];
               if (due_tbl[best] > TimeMax - TimeBits'(period_tbl[best]))
                  due_tbl[best] = TimeMax;
               else
                  due_tbl[best] = due_tbl[best] + TimeBits'(period_tbl[best]);
            end
         end
         default: begin
            source_count = 0;
            res.status = ST_CLEARED;
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_item(op_type op, int id, int per);
      req_type r;
      r.operation = op;
      r.source_id = IdBits'(id);
      r.period = PeriodBits'(per);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_item <= '0;
         gap_cycles <= 0;
      end else if (start && !busy) begin
         expected_rsps.push_back(schedule_step(req_item));
         if (pending_items.size() > 150 && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            gap_cycles <= $urandom_range(0, 4);
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_cycles > 0) begin
            gap_cycles <= gap_cycles - 1;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d id %h time %h",
                        rsp_item.status, rsp_item.dispatched_id, rsp_item.dispatch_time);
         end else begin
            rsp_type want;
            want = expected_rsps.pop_front();
            if (rsp_item.status !== want.status ||
                rsp_item.dispatched_id !== want.dispatched_id ||
                rsp_item.dispatch_time !== want.dispatch_time) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d id %h time %h, got %0d %h %h",
                           want.status, want.dispatched_id, want.dispatch_time,
                           rsp_item.status, rsp_item.dispatched_id,
                           rsp_item.dispatch_time);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("periodic_dispatch_scheduler_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      int n;
      reset = 1'b1;

      pending_items.push_back(make_item(OP_DISPATCH, 0, 0));
      pending_items.push_back(make_item(OP_REGISTER, 16'hffff, 16'hffff));
      pending_items.push_back(make_item(OP_REGISTER, 0, 1));
      pending_items.push_back(make_item(OP_REGISTER, 7, 0));
      pending_items.push_back(make_item(OP_REGISTER, 5, 1));
      pending_items.push_back(make_item(OP_REGISTER, 5, 1));
      for (int i = 0; i < 6; i++)
         pending_items.push_back(make_item(OP_DISPATCH, 16'hffff, 16'hffff));
      for (int i = 0; i < 60; i++)
         pending_items.push_back(make_item(OP_REGISTER, $urandom, $urandom_range(1, 65535)));
      pending_items.push_back(make_item(OP_REGISTER, 1, 1));
      pending_items.push_back(make_item(OP_DISPATCH, 0, 0));
      pending_items.push_back(make_item(OP_CLEAR_B, 0, 0));
      pending_items.push_back(make_item(OP_DISPATCH, 0, 0));
      pending_items.push_back(make_item(OP_REGISTER, 3, 2));
      pending_items.push_back(make_item(OP_CLEAR, 16'hffff, 16'hffff));

      // random cases: clear, fill, dispatch, with some noise
      while (pending_items.size() < 1750) begin
         pending_items.push_back(make_item($urandom_range(0, 1) ? OP_CLEAR : OP_CLEAR_B,
                                           $urandom, $urandom));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
         for (int i = 0; i < n; i++)
            pending_items.push_back(make_item(OP_REGISTER,
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom,
               ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2) : $urandom));
         n = $urandom_range(1, 40);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               pending_items.push_back(make_item(op_type'($urandom_range(0, 3)),
                                                 $urandom, $urandom));
            else
               pending_items.push_back(make_item(OP_DISPATCH, $urandom, $urandom));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && !start && expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("periodic_dispatch_scheduler_core verification clean");
      else
         $display("periodic_dispatch_scheduler_core verification failed");
      $finish;
   end
endmodule

// File: files.f
hw/rtl/pds_pkg.sv
hw/rtl/pds_ram.sv
hw/rtl/periodic_dispatch_scheduler_core.sv
test/periodic_dispatch_scheduler_core_tb.sv
